// ===== hw/rtl/bixd_pkg.sv =====
// Package for the interleaved block XOR decrypt unit.
// Holds default widths, register reset values and the register index codes.
// No dependencies.
package bixd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int BLOCK_BITS_DEF  = 16;
	localparam int KEY_W           = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int BLOCK_RESET     = 1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_SIZE    = 3'd0,
		REG_SOURCE_LENGTH = 3'd1,
		REG_DEST_LENGTH   = 3'd2,
		REG_START_KEY     = 3'd3,
		REG_KEY_STEP      = 3'd4,
		REG_BLOCK_SIZE    = 3'd5,
		REG_BYTE_LIMIT    = 3'd6
	} cfg_reg_t;

endpackage

// ===== hw/rtl/block_interleave_xor_decrypt_unit.sv =====
// Top level of the interleaved block XOR decrypt unit.
// Depends on bixd_pkg and bixd_rem_div.
//
// Usage: source bytes enter on the src channel (src_valid, src_stall, src_byte), one byte
// per transaction. Each byte that falls inside total_size yields one transaction on the out
// channel (out_valid, out_stall) carrying the decrypted or passed byte, its absolute
// destination offset, a write_enable flag and a last flag; bytes beyond total_size are
// consumed and yield nothing.
// Configuration goes through a plain write port (cfg_we, cfg_index, cfg_wdata). Every write
// to a defined register restarts the run: the block stalls its input while a bit-serial
// remainder unit works out total_size modulo block_size and the initial run record is
// stored. Reset starts the same pass.
// Throughput is one byte per cycle while neither a receiver stall nor a restart holds the
// input. The run record sits in a one-word synchronous memory; each byte reads it when
// accepted, is processed in the next cycle and writes it back, with a bypass register
// covering back-to-back bytes. A result passes the processing stage and the output register
// before out_valid rises. When the receiver stalls, the result holds in the output
// register, one more byte can wait in the processing stage, and then src_stall rises.
module block_interleave_xor_decrypt_unit
	import bixd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [((LENGTH_BITS > BLOCK_BITS) ? LENGTH_BITS : BLOCK_BITS)-1:0] cfg_wdata,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  logic [KEY_W-1:0]       src_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [KEY_W-1:0]       out_byte,
	output logic [LENGTH_BITS-1:0] dest_offset,
	output logic                   write_enable,
	output logic                   last
);

	localparam int L  = LENGTH_BITS;
	localparam int BB = BLOCK_BITS;
	localparam int AW = (L > BB + 1) ? L : BB + 1;
	localparam int NW = (L > BB) ? L : BB;

	// Run record kept in the state memory.
	typedef struct packed {
		logic [L-1:0]        pos;
		logic [L-1:0]        enc_rem;
		logic signed [L:0]   limit_rem;
		logic [BB-1:0]       blk_rem;
		logic [BB-1:0]       hi_rem;
		logic [L-1:0]        off;
		logic [L-1:0]        second_off;
		logic [L:0]          blk_end;
		logic [KEY_W-1:0]    key;
		logic                stopped;
	} state_t;

	typedef enum logic [3:0] {
		ST_START = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_LOAD  = 4'b0100,
		ST_IDLE  = 4'b1000
	} seq_t;

	// Configuration registers.
	logic [L-1:0]     total_q;
	logic [L-1:0]     source_q;
	logic [L-1:0]     dest_q;
	logic [KEY_W-1:0] start_key_q;
	logic [KEY_W-1:0] key_step_q;
	logic [BB-1:0]    block_q;
	logic [L-1:0]     limit_q;
	logic             restart;

	always_comb begin
		restart = 1'b0;
		if (cfg_we) begin
			case (cfg_index) inside
				[REG_TOTAL_SIZE:REG_BYTE_LIMIT]: restart = 1'b1;
				default:                          restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			source_q    <= '0;
			dest_q      <= '1;
			start_key_q <= '0;
			key_step_q  <= '0;
			block_q     <= BB'(BLOCK_RESET);
			limit_q     <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL_SIZE:    total_q     <= cfg_wdata[L-1:0];
				REG_SOURCE_LENGTH: source_q    <= cfg_wdata[L-1:0];
				REG_DEST_LENGTH:   dest_q      <= cfg_wdata[L-1:0];
				REG_START_KEY:     start_key_q <= cfg_wdata[KEY_W-1:0];
				REG_KEY_STEP:      key_step_q  <= cfg_wdata[KEY_W-1:0];
				REG_BLOCK_SIZE:    block_q     <= cfg_wdata[BB-1:0];
				REG_BYTE_LIMIT:    limit_q     <= cfg_wdata[L-1:0];
				default: ;
			endcase
		end
	end

	// A zero block size behaves as a block size of one.
	logic [BB-1:0] eff_b;
	assign eff_b = (block_q == '0) ? BB'(1) : block_q;

	// Restart sequencer and the remainder unit behind it.
	seq_t          seq_q;
	logic          div_done;
	logic [BB-1:0] div_rem;

	bixd_rem_div #(
		.L  (L),
		.BB (BB)
	) u_rem_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (seq_q == ST_START),
		.dividend  (total_q),
		.divisor   (eff_b),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= ST_START;
		end else if (restart) begin
			seq_q <= ST_START;
		end else begin
			case (seq_q)
				ST_START: seq_q <= ST_DIV;
				ST_DIV:   if (div_done) seq_q <= ST_LOAD;
				ST_LOAD:  seq_q <= ST_IDLE;
				ST_IDLE:  seq_q <= ST_IDLE;
				default:  seq_q <= ST_START;
			endcase
		end
	end

	// The tail is the remainder when it is under a quarter block, plus one byte for
	// an odd size; the encrypted length is what is left of total_size.
	logic [BB-1:0] tail_base;
	logic [BB:0]   tail;
	logic [L-1:0]  enc_len;
	state_t        init_rec;

	always_comb begin
		tail_base = (div_rem >= (eff_b >> 2)) ? '0 : div_rem;
		tail      = {1'b0, tail_base} + (BB+1)'(total_q[0]);
		enc_len   = (AW'(tail) > AW'(total_q)) ? '0 : total_q - L'(tail);

		init_rec            = '0;
		init_rec.enc_rem    = enc_len;
		init_rec.limit_rem  = {1'b0, limit_q};
		init_rec.key        = start_key_q;
		init_rec.stopped    = total_q > source_q;
	end

	// Input accept, state read and processing stage.
	logic             accept;
	logic             valid_s1;
	logic             fwd_s1;
	logic [KEY_W-1:0] src_byte_s1;
	state_t           rd_s1;
	state_t           state_mem;
	state_t           wr_q;
	logic             mem_we;
	state_t           wr_data;
	logic             s1_fire;

	logic             out_valid_q;
	logic [KEY_W-1:0] out_byte_q;
	logic [L-1:0]     out_offset_q;
	logic             out_we_q;
	logic             out_last_q;

	state_t           st;
	state_t           st_next;
	logic             no_res;
	logic             start_blk;
	logic             in_blk;
	logic [BB-1:0]    n_blk;
	logic [L-1:0]     n_len;
	logic [BB-1:0]    half;
	logic [L-1:0]     off_c;
	logic [L-1:0]     sec_c;
	logic [BB-1:0]    hi_c;
	logic [BB-1:0]    rem_c;
	logic [L:0]       end_c;
	logic [L-1:0]     res_offset;
	logic [KEY_W-1:0] res_byte;
	logic             res_we;
	logic             res_last;

	always_comb begin
		st        = fwd_s1 ? wr_q : rd_s1;
		no_res    = st.pos >= total_q;
		n_blk     = (NW'(st.enc_rem) < NW'(eff_b)) ? BB'(st.enc_rem) : eff_b;
		n_len     = L'(n_blk);
		half      = {1'b0, n_blk[BB-1:1]} + BB'(n_blk[0]);
		start_blk = (st.blk_rem == '0) && (st.enc_rem != '0) &&
			!st.limit_rem[L] && (st.limit_rem != '0);
		in_blk    = (st.blk_rem != '0) || start_blk;

		off_c = start_blk ? (st.pos + n_len - L'(1)) : st.off;
		sec_c = start_blk ? (st.pos + n_len - L'(2)) : st.second_off;
		hi_c  = start_blk ? half : st.hi_rem;
		rem_c = start_blk ? n_blk : st.blk_rem;
		end_c = start_blk ? ({1'b0, st.pos} + {1'b0, n_len}) : st.blk_end;

		st_next     = st;
		st_next.pos = st.pos + L'(1);
		if (in_blk) begin
			res_offset         = off_c;
			res_byte           = src_byte_s1 ^ st.key;
			st_next.key        = st.key + key_step_q;
			st_next.enc_rem    = st.enc_rem - L'(1);
			st_next.limit_rem  = st.limit_rem - (L+1)'(1);
			st_next.blk_rem    = rem_c - BB'(1);
			st_next.hi_rem     = (hi_c == '0) ? '0 : hi_c - BB'(1);
			// The first half walks down from the block's top; then the second
			// half starts one below it.
			st_next.off        = (hi_c == BB'(1)) ? sec_c : off_c - L'(2);
			st_next.second_off = sec_c;
			st_next.blk_end    = end_c;
			st_next.stopped    = st.stopped ||
				((rem_c == BB'(1)) && (end_c > {1'b0, dest_q}));
		end else begin
			res_offset      = st.pos;
			res_byte        = src_byte_s1;
			st_next.stopped = st.stopped || (st.pos >= dest_q);
		end
		res_we   = !st.stopped && (res_offset < dest_q);
		res_last = ({1'b0, st.pos} + (L+1)'(1)) == {1'b0, total_q};
	end

	assign s1_fire   = valid_s1 && (no_res || !out_valid_q || !out_stall);
	assign src_stall = (seq_q != ST_IDLE) || (valid_s1 && !s1_fire);
	assign accept    = src_valid && !src_stall;

	always_comb begin
		mem_we  = 1'b0;
		wr_data = st_next;
		if (seq_q == ST_LOAD) begin
			mem_we  = 1'b1;
			wr_data = init_rec;
		end else if (s1_fire && !no_res) begin
			mem_we = 1'b1;
		end
	end

	// One-word state memory with a registered read port and a bypass copy
	// of the last write for a byte that reads while the previous one writes.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem <= wr_data;
			wr_q      <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1       <= state_mem;
			src_byte_s1 <= src_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= mem_we;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && !no_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && !no_res) begin
			out_byte_q   <= res_byte;
			out_offset_q <= res_offset;
			out_we_q     <= res_we;
			out_last_q   <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign dest_offset  = out_offset_q;
	assign write_enable = out_we_q;
	assign last         = out_last_q;

endmodule

// ===== hw/rtl/bixd_rem_div.sv =====
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
// Standalone; instantiated by the interleave decrypt top level.
module bixd_rem_div #(
	parameter int L  = 24,
	parameter int BB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [L-1:0]  dividend,
	input  logic [BB-1:0] divisor,
	output logic          done,
	output logic [BB-1:0] remainder
);

	localparam int CW = (L > 1) ? $clog2(L) : 1;

	logic          running_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [BB-1:0] rem_q;
	logic [BB:0]   trial;
	logic [BB:0]   diff;
	logic [BB-1:0] rem_next;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial    = {rem_q, dividend[cnt_q]};
		diff     = trial - {1'b0, divisor};
		rem_next = (trial >= {1'b0, divisor}) ? diff[BB-1:0] : trial[BB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			done_q    <= 1'b0;
			cnt_q     <= CW'(L - 1);
		end else if (running_q) begin
			if (cnt_q == '0) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end else begin
				done_q <= 1'b0;
				cnt_q  <= cnt_q - CW'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
		end else if (running_q) begin
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/bixd_checker.sv =====
// Port-level checker for the interleaved block XOR decrypt unit, with its bind.
// Depends on bixd_pkg and binds to block_interleave_xor_decrypt_unit.
module bixd_checker
	import bixd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_we,
	input logic [CFG_IDX_W-1:0]   cfg_index,
	input logic                   src_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [KEY_W-1:0]       out_byte,
	input logic [LENGTH_BITS-1:0] dest_offset
);

	// A result held by the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A held result keeps its byte and offset.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(dest_offset))
		else $error("out payload changed while stalled");

	// A register write restarts the run, which holds off the input.
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index <= REG_BYTE_LIMIT) |=> src_stall)
		else $error("input taken right after a register write");

	// No source byte is taken while in reset.
	a_reset_stall: assert property (@(posedge clk)
		!arst_n |-> src_stall)
		else $error("input not stalled during reset");

endmodule

bind block_interleave_xor_decrypt_unit bixd_checker #(
	.LENGTH_BITS (LENGTH_BITS)
) u_bixd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.src_stall   (src_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.dest_offset (dest_offset)
);

// ===== bench/block_interleave_xor_decrypt_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for block_interleave_xor_decrypt_unit.
// Needs bixd_pkg and the unit's RTL; a scoreboard class predicts every output transaction.
module block_interleave_xor_decrypt_unit_tb;
	import bixd_pkg::*;

	localparam int LEN_W = LENGTH_BITS_DEF;
	localparam int BLK_W = BLOCK_BITS_DEF;
	localparam int CFG_W = (LEN_W > BLK_W) ? LEN_W : BLK_W;
	localparam bit [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam bit [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};
	// Index 7 names no register; a write to it must leave the run untouched.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 600;
	// A byte past total_size leaves the processing stage in the cycle after it is
	// taken and yields no output transaction, so after the last result we let
	// this many cycles go by before touching the registers.
	localparam int SETTLE_CYCLES = 6;
	localparam longint TIMEOUT_NS = 10_000_000;

	// One destination write as the unit presents it on its output channel.
	typedef struct packed {
		logic [KEY_W-1:0] data;
		logic [LEN_W-1:0] offset;
		logic             we;
		logic             is_last;
	} dest_write_t;

	// The scoreboard keeps its own copy of the registers and of the run record,
	// predicts one destination write per accepted byte inside total_size and checks the writes
	// that leave the unit in order.
	class decrypt_scoreboard;
		bit [LEN_W-1:0] total_size, source_length, dest_length, byte_limit;
		bit [KEY_W-1:0] start_key, key_step;
		bit [BLK_W-1:0] block_size;
		bit [LEN_W-1:0] position, enc_left, blk_start;
		longint         limit_left;
		bit [BLK_W-1:0] blk_len, blk_idx;
		bit [KEY_W-1:0] key;
		bit             halted;
		dest_write_t    expected_q[$];
		int             errors;

		function int unsigned eff_block();
			return (block_size == 0) ? 1 : block_size;
		endfunction

		// Fixes the encrypted length once and rewinds the stream.
		function void restart_run();
			int unsigned b, a;
			b = eff_block();
			a = total_size % b;
			if (a >= b / 4)
				a = 0;
			a += total_size % 2;
			enc_left   = (a > total_size) ? '0 : LEN_W'(total_size - a);
			limit_left = byte_limit;
			key        = start_key;
			position   = '0;
			blk_start  = '0;
			blk_len    = '0;
			blk_idx    = '0;
			halted     = total_size > source_length;
		endfunction

		function void load_defaults();
			total_size    = '0;
			source_length = '0;
			dest_length   = LEN_MAX;
			start_key     = '0;
			key_step      = '0;
			block_size    = BLK_W'(BLOCK_RESET);
			byte_limit    = LEN_MAX;
			restart_run();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_TOTAL_SIZE:    total_size    = data[LEN_W-1:0];
				REG_SOURCE_LENGTH: source_length = data[LEN_W-1:0];
				REG_DEST_LENGTH:   dest_length   = data[LEN_W-1:0];
				REG_START_KEY:     start_key     = data[KEY_W-1:0];
				REG_KEY_STEP:      key_step      = data[KEY_W-1:0];
				REG_BLOCK_SIZE:    block_size    = data[BLK_W-1:0];
				REG_BYTE_LIMIT:    byte_limit    = data[LEN_W-1:0];
				default:           return;
			endcase
			restart_run();
		endfunction

		// Returns 1 when the byte falls inside the run and a write is expected.
		function bit note_input(bit [KEY_W-1:0] src);
			dest_write_t want;
			int unsigned n, k, half, rel;
			if (position >= total_size)
				return 0;
			if (blk_len == 0 || blk_idx >= blk_len) begin
				if (enc_left > 0 && limit_left > 0) begin
					blk_len   = BLK_W'((enc_left < eff_block()) ? enc_left : eff_block());
					blk_start = position;
					blk_idx   = '0;
				end else begin
					blk_len = '0;
				end
			end
			if (blk_len != 0) begin
				n    = blk_len;
				k    = blk_idx;
				half = (n + 1) / 2;
				rel  = (k < half) ? (n - 1 - 2 * k) : (n - 2 - 2 * (k - half));
				want.offset = LEN_W'(blk_start + rel);
				want.data   = src ^ key;
				key         = key + key_step;
				want.we     = !halted && want.offset < dest_length;
				enc_left    = enc_left - 1'b1;
				limit_left  = limit_left - 1;
				blk_idx     = BLK_W'(k + 1);
				if (k + 1 >= n && longint'(blk_start) + n > dest_length)
					halted = 1'b1;
			end else begin
				want.offset = position;
				want.data   = src;
				want.we     = !halted && want.offset < dest_length;
				if (want.offset >= dest_length)
					halted = 1'b1;
			end
			want.is_last = (32'(position) + 32'd1) == 32'(total_size);
			position = position + 1'b1;
			expected_q.push_back(want);
			return 1;
		endfunction

		function void check_result(dest_write_t got);
			dest_write_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output transaction %p", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.data !== want.data) begin
				$display("%0t: out_byte expected %02h, got %02h", $time, want.data, got.data);
				errors++;
			end
			if (got.offset !== want.offset) begin
				$display("%0t: dest_offset expected %06h, got %06h", $time, want.offset,
					got.offset);
				errors++;
			end
			if (got.we !== want.we) begin
				$display("%0t: write_enable expected %b, got %b", $time, want.we, got.we);
				errors++;
			end
			if (got.is_last !== want.is_last) begin
				$display("%0t: last expected %b, got %b", $time, want.is_last, got.is_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 src_valid;
	logic                 src_stall;
	logic [KEY_W-1:0]     src_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [KEY_W-1:0]     out_byte;
	logic [LEN_W-1:0]     dest_offset;
	logic                 write_enable;
	logic                 last;

	decrypt_scoreboard sb = new();
	// Counts the bytes that produced an expected write; ignored bytes do not count.
	int predicted_items;

	block_interleave_xor_decrypt_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.src_byte     (src_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.dest_offset  (dest_offset),
		.write_enable (write_enable),
		.last         (last)
	);

	always #10 clk = ~clk;

	// Output monitor. Every stimulus signal changes through nonblocking
	// assignments, so at the edge this block sees the values that the unit
	// itself sampled.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{out_byte, dest_offset, write_enable, last});
	end

	// Receiver back-pressure: mostly short free and stalled stretches, now and
	// then a long stall or a long stretch with no stall at all. Both lengths are
	// at least one so out_stall gets one assignment per edge.
	initial begin
		int free_len, hold_len;
		out_stall <= 1'b0;
		forever begin
			free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 8);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(1, 3);
			repeat (free_len) @(posedge clk);
			out_stall <= 1'b1;
			repeat (hold_len) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	// Mostly back-to-back or short gaps, with a few long ones. A burst run never
	// idles the sender.
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// One source transaction. Returns at the edge that accepted the byte; the
	// caller decides whether valid stays high for the next one.
	task automatic send_byte(input logic [KEY_W-1:0] b);
		src_valid <= 1'b1;
		src_byte  <= b;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		if (sb.note_input(b))
			predicted_items++;
	endtask

	// Waits until every predicted write has left the unit, then gives a byte
	// that yields no write time to drain out of the pipeline.
	task automatic quiesce();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Programs all seven registers for a new run. The narrow registers get
	// random junk above their width, which the unit must drop.
	task automatic program_run(input bit [LEN_W-1:0] tot, input bit [LEN_W-1:0] src_len,
		input bit [LEN_W-1:0] dst_len, input bit [KEY_W-1:0] k0, input bit [KEY_W-1:0] ks,
		input bit [BLK_W-1:0] blk, input bit [LEN_W-1:0] limit);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		quiesce();
		cfg_write(REG_TOTAL_SIZE, tot);
		cfg_write(REG_SOURCE_LENGTH, src_len);
		cfg_write(REG_DEST_LENGTH, dst_len);
		cfg_write(REG_START_KEY, {junk[CFG_W-1:KEY_W], k0});
		cfg_write(REG_KEY_STEP, {junk[CFG_W-KEY_W-1:0], ks});
		cfg_write(REG_BLOCK_SIZE, {junk[CFG_W-BLK_W-1:0], blk});
		cfg_write(REG_BYTE_LIMIT, limit);
	endtask

	// Streams count bytes, all-zero and all-one bytes mixed in with random ones.
	// Now and then the sender holds off until every expected write has come.
	task automatic run_bytes(input int count, input bit burst);
		int gap, r;
		logic [KEY_W-1:0] b;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 7);
			b = (r == 0) ? '0 : (r == 1) ? '1 : KEY_W'($urandom);
			send_byte(b);
			if (!burst && $urandom_range(0, 49) == 0) begin
				src_valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end else begin
				gap = pick_gap(burst);
				if (gap > 0) begin
					src_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// A run with random registers. Most runs are short with small blocks so that
	// block boundaries, the tail and the bounds all come up often; a few use
	// huge sizes, of which only a prefix is streamed.
	task automatic random_run();
		bit [LEN_W-1:0] tot, src_len, dst_len, limit;
		bit [BLK_W-1:0] blk;
		int unsigned    span;
		longint         padded;
		int             r, count;
		r = $urandom_range(0, 9);
		tot = (r == 0) ? LEN_W'($urandom) : (r == 1) ? LEN_MAX : LEN_W'($urandom_range(0, 40));
		span = (tot > 60) ? 60 : tot;
		r = $urandom_range(0, 9);
		padded = longint'(tot) + $urandom_range(0, 5);
		case (r)
			0:       src_len = LEN_W'($urandom);
			1:       src_len = (tot == 0) ? '0 : tot - 1'b1;
			2:       src_len = LEN_MAX;
			default: src_len = (padded > LEN_MAX) ? LEN_MAX : LEN_W'(padded);
		endcase
		r = $urandom_range(0, 9);
		if (r < 5)
			dst_len = LEN_MAX;
		else if (r < 8)
			dst_len = LEN_W'($urandom_range(0, span + 4));
		else if (r == 8)
			dst_len = LEN_W'($urandom);
		else
			dst_len = '0;
		r = $urandom_range(0, 19);
		if (r == 0)
			blk = '0;
		else if (r == 1)
			blk = BLK_MAX;
		else if (r == 2)
			blk = BLK_W'($urandom);
		else if (r < 7)
			blk = BLK_W'($urandom_range(1, 3));
		else
			blk = BLK_W'($urandom_range(1, 12));
		r = $urandom_range(0, 9);
		if (r < 5)
			limit = LEN_MAX;
		else if (r < 9)
			limit = LEN_W'($urandom_range(0, span));
		else
			limit = LEN_W'($urandom);
		program_run(tot, src_len, dst_len, KEY_W'($urandom), KEY_W'($urandom), blk, limit);
		count = (tot <= 40) ? int'(tot) + int'($urandom_range(0, 3))
			: int'($urandom_range(5, 40));
		run_bytes(count, $urandom_range(0, 4) == 0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_TOTAL_SIZE;
		cfg_wdata <= '0;
		src_valid <= 1'b0;
		src_byte  <= '0;
		predicted_items = 0;
		sb.load_defaults();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Straight after reset total_size is zero: bytes are consumed past the
		// end of the run and must not produce any output transaction.
		run_bytes(2, 1'b0);

		// Two blocks and a one-byte tail, with the key and its step at maximum.
		// Halfway through, a write to the unused index must not restart the run.
		program_run(9, 9, LEN_MAX, 8'hFF, 8'hFF, 5, LEN_MAX);
		run_bytes(4, 1'b0);
		quiesce();
		cfg_write(REG_UNUSED, CFG_W'($urandom));
		run_bytes(6, 1'b0);

		// Rejected run: total_size exceeds source_length, so nothing is written.
		program_run(3, 2, LEN_MAX, 8'h5A, 8'h01, 4, LEN_MAX);
		run_bytes(3, 1'b0);

		// Destination overrun inside the first block stops all later writes.
		program_run(6, 6, 3, 8'h00, 8'h10, 4, LEN_MAX);
		run_bytes(6, 1'b0);

		// Zero block size acts as one, and the byte limit runs out after two.
		program_run(4, 4, LEN_MAX, 8'h33, 8'h80, 0, 2);
		run_bytes(4, 1'b0);

		// Largest sizes with an empty destination; only a prefix is streamed.
		program_run(LEN_MAX, LEN_MAX, 0, 8'h00, 8'h00, BLK_MAX, LEN_MAX);
		run_bytes(2, 1'b0);

		// Random runs until enough bytes have produced a write.
		predicted_items = 0;
		while (predicted_items < RANDOM_ITEMS)
			random_run();

		quiesce();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
